>>> rtl/bsr_pkg.sv
`default_nettype none
package bsr_pkg;

   // fixed field widths
   localparam int OFFSET_W      = 21;
   localparam int HEADER_W      = 13;
   localparam int ENTRY_HDR_W   = 7;
   localparam int ALIGN_W       = 3;
   localparam int ALIGN_MASK_W  = 7;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 21;
   localparam int NEED_W        = OFFSET_W + 1;

   // capacity limit, applied on top of the buffer_bytes register
   localparam int MAX_BUFFER_BYTES = 1048576;
   localparam int MAX_W = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int CMP_W = (MAX_W > OFFSET_W + 2) ? MAX_W : OFFSET_W + 2;

   // register reset values
   localparam logic [OFFSET_W-1:0]    BUFFER_BYTES_RST = 21'd65536;
   localparam logic [HEADER_W-1:0]    HEADER_BYTES_RST = 13'd64;
   localparam logic [ENTRY_HDR_W-1:0] ENTRY_HDR_RST    = 7'd16;
   localparam logic [ALIGN_W-1:0]     ALIGN_LOG2_RST   = 3'd3;

   typedef enum logic [1:0] {
      OP_CHECKOUT  = 2'd0,
      OP_MARK_FULL = 2'd1,
      OP_CHECKIN   = 2'd2,
      OP_RESTART   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_RETRY       = 3'd1,
      ST_TOO_SMALL   = 3'd2,
      ST_FULL_ACTIVE = 3'd3,
      ST_FULL_IDLE   = 3'd4,
      ST_ALL_DONE    = 3'd5,
      ST_BAD_CHECKIN = 3'd6
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BUFFER_BYTES = 2'd0,
      CSR_HEADER_BYTES = 2'd1,
      CSR_ENTRY_HDR    = 2'd2,
      CSR_ALIGN_LOG2   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]    buffer_bytes;
      logic [HEADER_W-1:0]    header_bytes;
      logic [ENTRY_HDR_W-1:0] entry_header_bytes;
      logic [ALIGN_W-1:0]     align_log2;
   } cfg_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] fill_offset;
      logic [OFFSET_W-1:0] entries;
      logic [OFFSET_W-1:0] active_writers;
      logic                full_flag;
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [OFFSET_W-1:0] payload_bytes;
      logic [OFFSET_W-1:0] checkin_offset;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] entry_offset;
      logic [OFFSET_W-1:0] entries_total;
      logic [OFFSET_W-1:0] fill_bytes;
      logic                is_full;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/bsr_req_if.sv
`default_nettype none
interface bsr_req_if
   import bsr_pkg::*;
();
   logic                valid;
   logic                ready;
   op_type              operation;
   logic [OFFSET_W-1:0] payload_bytes;
   logic [OFFSET_W-1:0] checkin_offset;

   modport source (output valid, output operation, output payload_bytes,
                   output checkin_offset, input ready);
   modport sink (input valid, input operation, input payload_bytes,
                 input checkin_offset, output ready);
endinterface
`default_nettype wire

>>> rtl/bsr_rsp_if.sv
`default_nettype none
interface bsr_rsp_if
   import bsr_pkg::*;
();
   logic                valid;
   logic                ready;
   status_type          status;
   logic [OFFSET_W-1:0] entry_offset;
   logic [OFFSET_W-1:0] entries_total;
   logic [OFFSET_W-1:0] fill_bytes;
   logic                is_full;

   modport source (output valid, output status, output entry_offset,
                   output entries_total, output fill_bytes, output is_full,
                   input ready);
   modport sink (input valid, input status, input entry_offset,
                 input entries_total, input fill_bytes, input is_full,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/bsr_csr.sv
`default_nettype none
module bsr_csr
   import bsr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BUFFER_BYTES: cfg_in.buffer_bytes       = csr_wr_data[OFFSET_W-1:0];
            CSR_HEADER_BYTES: cfg_in.header_bytes       = csr_wr_data[HEADER_W-1:0];
            CSR_ENTRY_HDR:    cfg_in.entry_header_bytes = csr_wr_data[ENTRY_HDR_W-1:0];
            CSR_ALIGN_LOG2:   cfg_in.align_log2         = csr_wr_data[ALIGN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_bytes       <= BUFFER_BYTES_RST;
         cfg_ff.header_bytes       <= HEADER_BYTES_RST;
         cfg_ff.entry_header_bytes <= ENTRY_HDR_RST;
         cfg_ff.align_log2         <= ALIGN_LOG2_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> rtl/bsr_step.sv
`default_nettype none
module bsr_step
   import bsr_pkg::*;
(
   input  wire cfg_type   cfg,
   input  wire state_type cur,
   input  wire req_type   req,
   output state_type      nxt,
   output rsp_type        rsp
);

   logic [ALIGN_MASK_W-1:0] align_mask;
   logic [NEED_W-1:0]       need_raw;
   logic [NEED_W-1:0]       need;
   logic [CMP_W-1:0]        end_sum;
   logic [CMP_W-1:0]        buf_ext;
   logic [CMP_W-1:0]        cap;
   logic                    room;
   logic [OFFSET_W-1:0]     granted;
   logic [OFFSET_W-1:0]     writers_dec;
   logic                    bad_checkin;

   always_comb begin
      // entry size rounded up to the alignment
      align_mask = ALIGN_MASK_W'((8'd1 << cfg.align_log2) - 8'd1);
      need_raw   = NEED_W'(req.payload_bytes) + NEED_W'(cfg.entry_header_bytes)
                   + NEED_W'(align_mask);
      need       = need_raw & ~NEED_W'(align_mask);
      end_sum    = CMP_W'(cur.fill_offset) + CMP_W'(need);
      buf_ext    = CMP_W'(cfg.buffer_bytes);
      cap        = (buf_ext > CMP_W'(MAX_BUFFER_BYTES)) ? CMP_W'(MAX_BUFFER_BYTES) : buf_ext;
      room       = (end_sum <= cap) && (cur.entries != '1) && (cur.active_writers != '1);
      granted    = cur.fill_offset + OFFSET_W'(cfg.entry_header_bytes);
      writers_dec = cur.active_writers - OFFSET_W'(1);
      bad_checkin = (cur.active_writers == '0) || (req.checkin_offset >= cur.fill_offset);

      nxt              = cur;
      rsp.status       = ST_OK;
      rsp.entry_offset = '0;

      case (req.operation)
         OP_CHECKOUT: begin
            if (cur.full_flag) begin
               rsp.status = ST_RETRY;
            end else if (room) begin
               rsp.entry_offset   = granted;
               nxt.fill_offset    = end_sum[OFFSET_W-1:0];
               nxt.entries        = cur.entries + OFFSET_W'(1);
               nxt.active_writers = cur.active_writers + OFFSET_W'(1);
            end else if (cur.entries == '0) begin
               rsp.status = ST_TOO_SMALL;
            end else begin
               nxt.full_flag = 1'b1;
               rsp.status    = (cur.active_writers != '0) ? ST_FULL_ACTIVE : ST_FULL_IDLE;
            end
         end
         OP_MARK_FULL: begin
            if (cur.full_flag) begin
               rsp.status = ST_RETRY;
            end else if (cur.entries != '0) begin
               nxt.full_flag = 1'b1;
               rsp.status    = (cur.active_writers != '0) ? ST_FULL_ACTIVE : ST_FULL_IDLE;
            end
         end
         OP_CHECKIN: begin
            if (bad_checkin) begin
               rsp.status = ST_BAD_CHECKIN;
            end else begin
               nxt.active_writers = writers_dec;
               rsp.status = ((writers_dec == '0) && cur.full_flag) ? ST_ALL_DONE : ST_OK;
            end
         end
         OP_RESTART: begin
            nxt.fill_offset    = OFFSET_W'(cfg.header_bytes);
            nxt.entries        = '0;
            nxt.active_writers = '0;
            nxt.full_flag      = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase

      rsp.entries_total = nxt.entries;
      rsp.fill_bytes    = nxt.fill_offset;
      rsp.is_full       = nxt.full_flag;
   end

endmodule
`default_nettype wire

>>> rtl/buffer_space_reservation_core.sv
`default_nettype none
// buffer space reservation core: bump pointer allocator for a record buffer
//
// req_if carries one request per transfer: checkout, mark full, checkin or
// restart. rsp_if returns exactly one result per request, in order, with the
// status, granted payload offset and the entry count, fill offset and full
// flag after the request. csr_* writes the four setup registers (capacity,
// buffer header, entry header, alignment); write them only while idle.
//
// a request is held in the input register, then one pass of add/align/compare
// writes the result register, and the allocator state is updated at the same
// edge. throughput: one request per cycle while rsp_if.ready stays high.
//
// reset clears the allocator state (fill offset to 64, counts and full flag
// to zero), both pipeline stages and restores the register defaults.
// when the receiver stalls, the result register holds, the input register
// fills, and req_if.ready drops; no transfer is lost or repeated.
module buffer_space_reservation_core
   import bsr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   bsr_req_if.sink                     req_if,
   bsr_rsp_if.source                   rsp_if,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   state_type step_nxt;
   rsp_type   step_rsp;

   // input register
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_req_ff;
   req_type   in_req_in;

   // result register
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_rsp_ff;
   rsp_type   out_rsp_in;

   logic      req_xfer;
   logic      rsp_xfer;
   logic      advance;

   bsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   bsr_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (in_req_ff),
      .nxt (step_nxt),
      .rsp (step_rsp)
   );

   // the held request moves on whenever the result slot is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_xfer    = req_if.valid && req_if.ready;
   assign rsp_xfer    = out_valid_ff && rsp_if.ready;

   always_comb begin
      in_req_in.operation      = req_if.operation;
      in_req_in.payload_bytes  = req_if.payload_bytes;
      in_req_in.checkin_offset = req_if.checkin_offset;

      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      // state commits together with the result it produced
      state_in   = advance ? step_nxt : state_ff;
      out_rsp_in = step_rsp;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.fill_offset    <= OFFSET_W'(HEADER_BYTES_RST);
         state_ff.entries        <= '0;
         state_ff.active_writers <= '0;
         state_ff.full_flag      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_req_ff <= in_req_in;
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.status        = out_rsp_ff.status;
   assign rsp_if.entry_offset  = out_rsp_ff.entry_offset;
   assign rsp_if.entries_total = out_rsp_ff.entries_total;
   assign rsp_if.fill_bytes    = out_rsp_ff.fill_bytes;
   assign rsp_if.is_full       = out_rsp_ff.is_full;

endmodule
`default_nettype wire
